// ===== hw/rtl/csmh_pkg.sv =====
// Shared constants, command and status types for the chained splitmix64 hash unit.
package csmh_pkg;

  localparam logic [63:0] GOLDEN_GAMMA = 64'h9e37_79b9_7f4a_7c15;
  localparam logic [63:0] MIX_MUL_A    = 64'hbf58_476d_1ce4_e5b9;
  localparam logic [63:0] MIX_MUL_B    = 64'h94d0_49bb_1331_11eb;
  localparam int unsigned MIX_SHIFT_A  = 30;
  localparam int unsigned MIX_SHIFT_B  = 27;
  localparam int unsigned MIX_SHIFT_C  = 31;

  localparam int unsigned WORD_W = 64;
  localparam int unsigned HALF_W = 32;

  typedef logic [1:0] part_t;
  localparam part_t PART_LO_LO = 2'd0;
  localparam part_t PART_LO_HI = 2'd1;
  localparam part_t PART_HI_LO = 2'd2;

  typedef struct packed {
    logic  load;
    logic  mul_en;
    logic  mul_b;
    part_t part;
    logic  finish;
  } dp_cmd_t;

  typedef struct packed {
    logic last;
  } dp_stat_t;

  function automatic logic [63:0] xorshift(input logic [63:0] v, input int unsigned sh);
    xorshift = v ^ (v >> sh);
  endfunction

endpackage

// ===== hw/rtl/csmh_if.sv =====
// Handshake channel interfaces for the input word stream and the hash results.
interface csmh_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] word;
  logic        last;

  modport source (output valid, output word, output last, input ready);
  modport sink   (input valid, input word, input last, output ready);
endinterface

interface csmh_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] hash_value;

  modport source (output valid, output hash_value, input ready);
  modport sink   (input valid, input hash_value, output ready);
endinterface

// ===== hw/rtl/csmh_datapath.sv =====
// Datapath: running hash, mixing register and a shared 32x32 partial-product multiplier.
module csmh_datapath (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [63:0]       word,
  input  logic              last,
  input  csmh_pkg::dp_cmd_t cmd,
  output csmh_pkg::dp_stat_t stat,
  output logic [63:0]       hash_value
);

  logic [63:0] run_r;
  logic [63:0] x_r;
  logic [63:0] acc_r;
  logic        last_r;
  logic [63:0] hash_r;

  logic [63:0] konst;
  logic [31:0] mul_x;
  logic [31:0] mul_k;
  logic [63:0] prod;
  logic [31:0] acc_hi_sum;
  logic [63:0] full;
  logic [63:0] premix;

  assign konst = cmd.mul_b ? csmh_pkg::MIX_MUL_B : csmh_pkg::MIX_MUL_A;

  always_comb begin
    case (cmd.part)
      csmh_pkg::PART_LO_LO: begin
        mul_x = x_r[31:0];
        mul_k = konst[31:0];
      end
      csmh_pkg::PART_LO_HI: begin
        mul_x = x_r[31:0];
        mul_k = konst[63:32];
      end
      csmh_pkg::PART_HI_LO: begin
        mul_x = x_r[63:32];
        mul_k = konst[31:0];
      end
      default: begin
        mul_x = x_r[31:0];
        mul_k = konst[31:0];
      end
    endcase
  end

  assign prod       = {32'd0, mul_x} * {32'd0, mul_k};
  assign acc_hi_sum = acc_r[63:32] + prod[31:0];
  assign full       = {acc_hi_sum, acc_r[31:0]};
  assign premix     = csmh_pkg::xorshift((run_r ^ word) + csmh_pkg::GOLDEN_GAMMA,
                                         csmh_pkg::MIX_SHIFT_A);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= '0;
    end else if (cmd.finish) begin
      run_r <= last_r ? 64'd0 : csmh_pkg::xorshift(full, csmh_pkg::MIX_SHIFT_C);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x_r    <= premix;
      last_r <= last;
    end else if (cmd.mul_en) begin
      case (cmd.part)
        csmh_pkg::PART_LO_LO: begin
          acc_r <= prod;
        end
        csmh_pkg::PART_LO_HI: begin
          acc_r[63:32] <= acc_hi_sum;
        end
        csmh_pkg::PART_HI_LO: begin
          if (!cmd.mul_b) begin
            x_r <= csmh_pkg::xorshift(full, csmh_pkg::MIX_SHIFT_B);
          end
        end
        default: begin
          acc_r <= acc_r;
        end
      endcase
    end
    if (cmd.finish && last_r) begin
      hash_r <= csmh_pkg::xorshift(full, csmh_pkg::MIX_SHIFT_C);
    end
  end

  assign stat.last  = last_r;
  assign hash_value = hash_r;

endmodule

// ===== hw/rtl/csmh_ctrl.sv =====
// Controller: sequences the partial products of both multiplies and owns the result valid.
module csmh_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  csmh_pkg::dp_stat_t stat,
  output csmh_pkg::dp_cmd_t  cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL_A,
    ST_MUL_B
  } state_t;

  state_t          state_r, state_nxt;
  csmh_pkg::part_t part_r, part_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic            last_step;
  logic            blocked;

  assign last_step = (part_r == csmh_pkg::PART_HI_LO);
  assign blocked   = stat.last && out_valid_r && !out_ready;

  always_comb begin
    cmd.load   = (state_r == ST_IDLE) && in_valid;
    cmd.mul_en = (state_r == ST_MUL_A) || (state_r == ST_MUL_B);
    cmd.mul_b  = (state_r == ST_MUL_B);
    cmd.part   = part_r;
    cmd.finish = (state_r == ST_MUL_B) && last_step && !blocked;
  end

  always_comb begin
    state_nxt     = state_r;
    part_nxt      = part_r;
    out_valid_nxt = (out_valid_r && !out_ready) || (cmd.finish && stat.last);
    case (state_r)
      ST_IDLE: begin
        part_nxt = csmh_pkg::PART_LO_LO;
        if (in_valid) begin
          state_nxt = ST_MUL_A;
        end
      end
      ST_MUL_A: begin
        if (last_step) begin
          state_nxt = ST_MUL_B;
          part_nxt  = csmh_pkg::PART_LO_LO;
        end else begin
          part_nxt = part_r + 2'd1;
        end
      end
      ST_MUL_B: begin
        if (last_step) begin
          if (cmd.finish) begin
            state_nxt = ST_IDLE;
            part_nxt  = csmh_pkg::PART_LO_LO;
          end
        end else begin
          part_nxt = part_r + 2'd1;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
        part_nxt  = csmh_pkg::PART_LO_LO;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      part_r      <= csmh_pkg::PART_LO_LO;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      part_r      <= part_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

endmodule

// ===== hw/rtl/chained_splitmix64_hash_unit.sv =====
// Top level of the chained splitmix64 hash unit.
//
//   Channel   Direction  Payload                  Handshake
//   in_chan   in         word[63:0], last         valid/ready
//   out_chan  out        hash_value[63:0]         valid/ready
//
// An item is folded into the running hash and has the gamma added, then each 64-bit multiply
// runs as three partial products on the single shared 32x32 multiplier.
// An array's hash is registered and offered in the cycle after its last item's final step.
// A result waiting in the output register does not stop the next item; only the final step
// of an array's last item waits while the output register is still full.
// Synchronous reset clears the running hash, the controller and the result valid.
module chained_splitmix64_hash_unit (
  input logic       clk,
  input logic       rst_n,
  csmh_in_if.sink   in_chan,
  csmh_out_if.source out_chan
);

  csmh_pkg::dp_cmd_t  ctl_cmd;
  csmh_pkg::dp_stat_t dp_stat;

  csmh_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .stat      (dp_stat),
    .cmd       (ctl_cmd)
  );

  csmh_datapath u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .word       (in_chan.word),
    .last       (in_chan.last),
    .cmd        (ctl_cmd),
    .stat       (dp_stat),
    .hash_value (out_chan.hash_value)
  );

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_chan.valid && in_chan.ready) |=> !in_chan.ready)
    else $error("Input accepted while a word was still being mixed.");

  a_result_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_chan.valid) |-> ($past(ctl_cmd.finish) && $past(dp_stat.last)))
    else $error("Result raised without the last word of an array finishing.");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl_cmd.finish && dp_stat.last) |-> (!out_chan.valid || out_chan.ready))
    else $error("Pending result would be overwritten.");

endmodule

// ===== verif/testbench.sv =====
// Self-checking testbench for the chained splitmix64 hash unit, using directed and random word streams.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT      = 400000;
  localparam int unsigned SINK_HOLD_CYCLES = 300;
  localparam int unsigned TAIL_CYCLES      = 24;
  localparam int unsigned RANDOM_ITEMS     = 465;

  logic clk;
  logic rst_n;

  csmh_in_if  in_chan ();
  csmh_out_if out_chan ();

  chained_splitmix64_hash_unit i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  logic [63:0] chain_hash;
  logic [63:0] expected_hashes[$];
  int unsigned fail_count;
  int unsigned cycle_count;
  bit          src_idle_en;
  bit          sink_idle_en;
  bit          sink_hold_req;
  bit          sink_flush;

  initial clk = 1'b0;
  always #1 clk = ~clk;

  function automatic logic [63:0] splitmix_finalise(input logic [63:0] x);
    logic [63:0] h;
    h = x + csmh_pkg::GOLDEN_GAMMA;
    h = h ^ (h >> csmh_pkg::MIX_SHIFT_A);
    h = h * csmh_pkg::MIX_MUL_A;
    h = h ^ (h >> csmh_pkg::MIX_SHIFT_B);
    h = h * csmh_pkg::MIX_MUL_B;
    h = h ^ (h >> csmh_pkg::MIX_SHIFT_C);
    return h;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (!src_idle_en) begin
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 55) begin
      return 0;
    end else if (r < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [63:0] pick_word();
    int unsigned r;
    int unsigned k;
    r = $urandom_range(0, 9);
    k = $urandom_range(0, 63);
    case (r)
      0: return '0;
      1: return '1;
      2: return 64'd1 << k;
      3: return ~(64'd1 << k);
      default: return {$urandom(), $urandom()};
    endcase
  endfunction

  // The item is predicted at the edge where it is accepted.
  task automatic send_word(input logic [63:0] w, input logic l);
    int unsigned gap;
    logic [63:0] mixed;
    gap = pick_gap();
    if (gap > 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_chan.valid <= 1'b1;
    in_chan.word  <= w;
    in_chan.last  <= l;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    mixed = splitmix_finalise(chain_hash ^ w);
    if (l) begin
      expected_hashes.push_back(mixed);
      chain_hash = '0;
    end else begin
      chain_hash = mixed;
    end
  endtask

  task automatic wait_for_results();
    in_chan.valid <= 1'b0;
    do @(posedge clk); while (expected_hashes.size() != 0);
  endtask

  task automatic send_array(input int unsigned len);
    for (int unsigned i = 0; i < len; i++) begin
      send_word(pick_word(), i == len - 1);
    end
  endtask

  task automatic test_directed_values();
    src_idle_en  = 1'b0;
    sink_idle_en = 1'b0;
    send_word('0, 1'b1);
    send_word('1, 1'b1);
    send_word(64'd1, 1'b1);
    send_word(64'h8000_0000_0000_0000, 1'b1);
    send_word(64'h5555_5555_5555_5555, 1'b1);
    send_word(64'haaaa_aaaa_aaaa_aaaa, 1'b1);
    // A word that cancels the gamma addition exactly, so the sum wraps to zero.
    send_word(-csmh_pkg::GOLDEN_GAMMA, 1'b1);
    send_word(64'h0000_0000_ffff_ffff, 1'b0);
    send_word(64'hffff_ffff_0000_0000, 1'b1);
    send_word('0, 1'b0);
    send_word('0, 1'b0);
    send_word('0, 1'b1);
    send_word('1, 1'b0);
    send_word('1, 1'b0);
    send_word('1, 1'b0);
    send_word('1, 1'b1);
    send_word(64'h0123_4567_89ab_cdef, 1'b0);
    send_word(64'hfedc_ba98_7654_3210, 1'b1);
    wait_for_results();
  endtask

  task automatic test_output_stall();
    src_idle_en   = 1'b0;
    sink_idle_en  = 1'b1;
    sink_hold_req = 1'b1;
    for (int unsigned i = 0; i < 30; i++) begin
      send_array($urandom_range(1, 2));
    end
  endtask

  task automatic test_sender_pause();
    src_idle_en  = 1'b1;
    sink_idle_en = 1'b1;
    for (int unsigned i = 0; i < 4; i++) begin
      send_array($urandom_range(1, 4));
    end
    wait_for_results();
    for (int unsigned i = 0; i < 4; i++) begin
      send_array($urandom_range(1, 4));
    end
  endtask

  task automatic test_random_arrays();
    int unsigned items;
    int unsigned len;
    int unsigned r;
    items = 0;
    src_idle_en  = 1'b1;
    sink_idle_en = 1'b1;
    while (items < RANDOM_ITEMS) begin
      r = $urandom_range(0, 99);
      if (r < 8) begin
        src_idle_en = ~src_idle_en;
      end else if (r < 16) begin
        sink_idle_en = ~sink_idle_en;
      end
      r = $urandom_range(0, 99);
      if (r < 45) begin
        len = 1;
      end else if (r < 93) begin
        len = $urandom_range(2, 6);
      end else begin
        len = $urandom_range(15, 35);
      end
      send_array(len);
      items += len;
    end
  endtask

  initial begin : result_sink
    int unsigned span;
    int unsigned hold_left;
    int unsigned r;
    logic        phase_ready;
    logic        rdy;
    logic [63:0] want;
    out_chan.ready = 1'b0;
    span        = 0;
    hold_left   = 0;
    phase_ready = 1'b1;
    forever begin
      @(posedge clk);
      if (rst_n && out_chan.valid && out_chan.ready) begin
        if (expected_hashes.size() == 0) begin
          $error("hash_value: no result expected, actual %h", out_chan.hash_value);
          fail_count++;
        end else begin
          want = expected_hashes.pop_front();
          if (out_chan.hash_value !== want) begin
            $error("hash_value: expected %h, actual %h", want, out_chan.hash_value);
            fail_count++;
          end
        end
      end
      if (sink_hold_req) begin
        sink_hold_req = 1'b0;
        hold_left     = SINK_HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        rdy = 1'b0;
      end else if (sink_flush || !sink_idle_en) begin
        rdy = 1'b1;
      end else begin
        if (span == 0) begin
          r = $urandom_range(0, 99);
          if (r < 60) begin
            phase_ready = 1'b1;
            span = $urandom_range(1, 8);
          end else if (r < 92) begin
            phase_ready = 1'b0;
            span = $urandom_range(1, 3);
          end else begin
            phase_ready = 1'b0;
            span = $urandom_range(15, 50);
          end
        end
        span--;
        rdy = phase_ready;
      end
      out_chan.ready <= rdy;
    end
  end

  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin : main_sequence
    rst_n         = 1'b0;
    in_chan.valid = 1'b0;
    in_chan.word  = '0;
    in_chan.last  = 1'b0;
    chain_hash    = '0;
    fail_count    = 0;
    src_idle_en   = 1'b0;
    sink_idle_en  = 1'b0;
    sink_hold_req = 1'b0;
    sink_flush    = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_values();
    test_output_stall();
    test_sender_pause();
    test_random_arrays();

    wait_for_results();
    sink_flush = 1'b1;
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
